>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VNF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold once the dly delay has passed after the antecedent.
`define VNF_ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("delayed assertion failed");

`endif

>>> rtl/vnf_pkg.sv
// Types and constants for the fixed-point vector normalizer
package vnf_pkg;

   localparam int DataWidth       = 32;
   localparam int FracBitsDefault = 16;

   typedef logic signed [DataWidth-1:0] comp_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] in_x;
      logic signed [DataWidth-1:0] in_y;
      logic signed [DataWidth-1:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] out_x;
      logic signed [DataWidth-1:0] out_y;
      logic signed [DataWidth-1:0] out_z;
   } rsp_type;

endpackage

>>> rtl/vector3_normalize_fixed.sv
// Pipelined fixed-point 3D vector normalizer (top level)
//
// Normalizes one signed fixed-point vector per clock: the receiver cannot
// stall, and busy is always low, so a transfer can be started every cycle.
// Each vector passes through the stages in order: one stage squares, one sums,
// the square root takes one pipeline stage per result bit and the reciprocal
// one stage per quotient bit, then one stage scales. A zero or wrapped-negative
// squared length passes the vector through.
`include "assert_macros.svh"

module vector3_normalize_fixed #(
   parameter int FRAC_BITS = vnf_pkg::FracBitsDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  vnf_pkg::req_type req_data,
   output logic             rsp_strobe,
   output vnf_pkg::rsp_type rsp_data
);

   localparam int DW  = vnf_pkg::DataWidth;
   localparam int K   = (DW + FRAC_BITS) / 2;   // square root result bits
   localparam int XW  = 2 * K;                  // radicand width
   localparam int RW  = K + 3;                  // root remainder width
   localparam int DS  = 2 * FRAC_BITS + 1;      // quotient bits
   localparam int LAT = K + DS + 3;

   localparam logic [DW-1:0] OneRaw = DW'(1) << FRAC_BITS;

   // ---- stage 1: squares
   logic                      s1_valid_ff;
   vnf_pkg::req_type          s1_vec_ff;
   logic signed [2*DW-1:0]    s1_sqx_ff, s1_sqy_ff, s1_sqz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
      s1_vec_ff <= req_data;
      s1_sqx_ff <= req_data.in_x * req_data.in_x;
      s1_sqy_ff <= req_data.in_y * req_data.in_y;
      s1_sqz_ff <= req_data.in_z * req_data.in_z;
   end

   // ---- stage 2: squared length, wrapped to the vector format
   logic [DW-1:0] n_sum;
   logic          n_pos;
   assign n_sum = s1_sqx_ff[FRAC_BITS+DW-1:FRAC_BITS] + s1_sqy_ff[FRAC_BITS+DW-1:FRAC_BITS]
                + s1_sqz_ff[FRAC_BITS+DW-1:FRAC_BITS];
   assign n_pos = !n_sum[DW-1] && (n_sum != '0);

   logic             sq_valid_ff [0:K];
   vnf_pkg::req_type sq_vec_ff   [0:K];
   logic             sq_pos_ff   [0:K];
   logic [XW-1:0]    sq_x_ff     [0:K];
   logic [RW-1:0]    sq_rem_ff   [0:K];
   logic [K-1:0]     sq_root_ff  [0:K];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else begin
         sq_valid_ff[0] <= s1_valid_ff;
      end
      sq_vec_ff[0]  <= s1_vec_ff;
      sq_pos_ff[0]  <= n_pos;
      sq_x_ff[0]    <= XW'({n_sum[DW-2:0], {FRAC_BITS{1'b0}}});
      sq_rem_ff[0]  <= '0;
      sq_root_ff[0] <= '0;
   end

   // ---- square root, one result bit per stage
   for (genvar k = 0; k < K; k++) begin : g_sqrt
      logic [RW-1:0] rem_sh;
      logic [RW-1:0] trial;
      logic [RW-1:0] rem_in;
      logic [K-1:0]  root_in;

      always_comb begin
         rem_sh = {sq_rem_ff[k][RW-3:0], sq_x_ff[k][XW-1 -: 2]};
         trial  = RW'({sq_root_ff[k], 2'b01});
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {sq_root_ff[k][K-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {sq_root_ff[k][K-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k+1] <= 1'b0;
         end else begin
            sq_valid_ff[k+1] <= sq_valid_ff[k];
         end
         sq_vec_ff[k+1]  <= sq_vec_ff[k];
         sq_pos_ff[k+1]  <= sq_pos_ff[k];
         sq_x_ff[k+1]    <= sq_x_ff[k] << 2;
         sq_rem_ff[k+1]  <= rem_in;
         sq_root_ff[k+1] <= root_in;
      end
   end

   // ---- reciprocal: 2^(2*FRAC_BITS) / s, one quotient bit per stage
   logic             dv_valid_ff [1:DS];
   vnf_pkg::req_type dv_vec_ff   [1:DS];
   logic             dv_pos_ff   [1:DS];
   logic [K-1:0]     dv_s_ff     [1:DS];
   logic [K-1:0]     dv_rem_ff   [1:DS];
   logic [DW-1:0]    dv_q_ff     [1:DS];

   for (genvar j = 1; j <= DS; j++) begin : g_div
      logic             src_valid;
      vnf_pkg::req_type src_vec;
      logic             src_pos;
      logic [K-1:0]     src_s;
      logic [K-1:0]     src_rem;
      logic [DW-1:0]    src_q;
      logic [K:0]       rem2;
      logic [K-1:0]     rem_in;
      logic [DW-1:0]    q_in;

      if (j == 1) begin : g_first
         assign src_valid = sq_valid_ff[K];
         assign src_vec   = sq_vec_ff[K];
         assign src_pos   = sq_pos_ff[K];
         assign src_s     = sq_root_ff[K];
         assign src_rem   = '0;
         assign src_q     = '0;
      end else begin : g_next
         assign src_valid = dv_valid_ff[j-1];
         assign src_vec   = dv_vec_ff[j-1];
         assign src_pos   = dv_pos_ff[j-1];
         assign src_s     = dv_s_ff[j-1];
         assign src_rem   = dv_rem_ff[j-1];
         assign src_q     = dv_q_ff[j-1];
      end

      always_comb begin
         // dividend is a single one bit, brought down first
         rem2 = {src_rem, (j == 1) ? 1'b1 : 1'b0};
         if (rem2 >= {1'b0, src_s}) begin
            rem_in = K'(rem2 - {1'b0, src_s});
            q_in   = {src_q[DW-2:0], 1'b1};
         end else begin
            rem_in = rem2[K-1:0];
            q_in   = {src_q[DW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else begin
            dv_valid_ff[j] <= src_valid;
         end
         dv_vec_ff[j] <= src_vec;
         dv_pos_ff[j] <= src_pos;
         dv_s_ff[j]   <= src_s;
         dv_rem_ff[j] <= rem_in;
         dv_q_ff[j]   <= q_in;
      end
   end

   // ---- scale
   vnf_pkg::comp_type      factor;
   logic signed [2*DW-1:0] px, py, pz;
   logic                   rsp_strobe_ff;
   vnf_pkg::rsp_type       rsp_data_ff;

   assign factor = dv_pos_ff[DS] ? dv_q_ff[DS] : OneRaw;
   assign px     = dv_vec_ff[DS].in_x * factor;
   assign py     = dv_vec_ff[DS].in_y * factor;
   assign pz     = dv_vec_ff[DS].in_z * factor;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv_valid_ff[DS];
      end
      rsp_data_ff.out_x <= px[FRAC_BITS+DW-1:FRAC_BITS];
      rsp_data_ff.out_y <= py[FRAC_BITS+DW-1:FRAC_BITS];
      rsp_data_ff.out_z <= pz[FRAC_BITS+DW-1:FRAC_BITS];
   end

   assign busy       = 1'b0;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // ---- checks
   `VNF_ASSERT_DELAY(a_latency, clock, reset, start, LAT, rsp_strobe)
   `VNF_ASSERT_DELAY(a_zero_pass, clock, reset, start && (req_data == '0), LAT, rsp_data == '0)
   `VNF_ASSERT_IMPLY(a_div_rem, clock, reset, dv_valid_ff[DS] && dv_pos_ff[DS], dv_rem_ff[DS] < dv_s_ff[DS])

endmodule

>>> bench/vector3_normalize_fixed_test.sv
// Randomized self-checking bench for the fixed-point 3D vector normalizer
module vector3_normalize_fixed_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = vnf_pkg::FracBitsDefault;
   localparam int DWID = vnf_pkg::DataWidth;
   localparam int LATENCY = 60;

   // Expected normalized vector for one input vector
   function automatic vnf_pkg::rsp_type normalize_vec(vnf_pkg::req_type r);
      logic signed [63:0] sq;
      logic signed [DWID-1:0] comp [3];
      logic signed [DWID-1:0] len2, fac, one;
      logic [95:0] rad, root, rem_v, trial;
      logic [127:0] num, quo;
      logic signed [127:0] prod;
      logic [DWID-1:0] sroot;
      vnf_pkg::rsp_type o;
      comp[0] = r.in_x; comp[1] = r.in_y; comp[2] = r.in_z;
      len2 = '0;
      for (int i = 0; i < 3; i++) begin
         sq = comp[i] * comp[i];
         len2 = len2 + DWID'(sq >>> FRAC);
      end
      one = DWID'(1) << FRAC;
      fac = one;
      if (len2 > 0) begin
         rad = 96'(unsigned'(len2)) << FRAC;
         root = '0;
         rem_v = '0;
         for (int b = 47; b >= 0; b--) begin
            rem_v = (rem_v << 2) | ((rad >> (2 * b)) & 96'd3);
            trial = (root << 2) | 96'd1;
            root = root << 1;
            if (rem_v >= trial) begin
               rem_v = rem_v - trial;
               root = root | 96'd1;
            end
         end
         sroot = root[DWID-1:0];
         if (sroot != 0) begin
            num = 128'(unsigned'(one)) << FRAC;
            quo = num / 128'(sroot);
            fac = quo[DWID-1:0];
         end
      end
      prod = 128'(comp[0]) * 128'(fac); o.out_x = DWID'(prod >>> FRAC);
      prod = 128'(comp[1]) * 128'(fac); o.out_y = DWID'(prod >>> FRAC);
      prod = 128'(comp[2]) * 128'(fac); o.out_z = DWID'(prod >>> FRAC);
      return o;
   endfunction

   class norm_scoreboard;
      vnf_pkg::rsp_type pending[$];
      int errors = 0;
      function void note_vector(vnf_pkg::req_type r);
         pending.push_back(normalize_vec(r));
      endfunction
      function void check_result(vnf_pkg::rsp_type got);
         vnf_pkg::rsp_type want;
         if (pending.size() == 0) begin
            $error("result with no pending vector");
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.out_x !== want.out_x) begin
            $error("out_x expected %h actual %h", want.out_x, got.out_x); errors++;
         end
         if (got.out_y !== want.out_y) begin
            $error("out_y expected %h actual %h", want.out_y, got.out_y); errors++;
         end
         if (got.out_z !== want.out_z) begin
            $error("out_z expected %h actual %h", want.out_z, got.out_z); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy, rsp_strobe;
   vnf_pkg::req_type req_data = '0;
   vnf_pkg::rsp_type rsp_data;
   norm_scoreboard board = new();
   logic [31:0] corner [8] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000,
                               32'h7fff_ffff, 32'h0001_0000, 32'hffff_0000, 32'h0000_0100};

   vector3_normalize_fixed i_dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_vector(req_data);
         if (rsp_strobe) board.check_result(rsp_data);
      end
   end

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($signed($urandom_range(0, 8191)) - 4096);
         3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         4: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // One start transfer; start stays high when the next vector follows at once
   task automatic send_vector(vnf_pkg::req_type r);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
            ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
      if (gap > 0 && start) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      vnf_pkg::req_type r;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int i = 0; i < 8; i++) begin
         r.in_x = corner[i]; r.in_y = corner[(i + 3) % 8]; r.in_z = corner[(i + 5) % 8];
         send_vector(r);
      end
      // equal components, zero vector, tiny vector (squared length truncates to zero)
      r = '{32'h0, 32'h0, 32'h0}; send_vector(r);
      r = '{32'h0000_0001, 32'h0, 32'h0}; send_vector(r);
      r = '{32'h0000_0010, 32'h0000_0010, 32'h0000_0010}; send_vector(r);
      r = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}; send_vector(r);
      r = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; send_vector(r);
      r = '{32'h0003_0000, 32'h0004_0000, 32'h0}; send_vector(r);
      for (int n = 0; n < 1450; n++) begin
         r.in_x = rand_comp(); r.in_y = rand_comp(); r.in_z = rand_comp();
         send_vector(r);
      end
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule
